FILE: src/dchd_pkg.sv
// Shared constants, types and helpers of the dark-channel haze detector.
package dchd_pkg;

   localparam int MAX_WIDTH_DEF  = 1024;
   localparam int MAX_HEIGHT_DEF = 1024;
   localparam int RADIUS_DEF     = 3;

   localparam int SIZE_W      = 11;
   localparam int THR_W       = 8;
   localparam int PIX_W       = 8;
   localparam int SUM_W       = 28;
   localparam int PH_W        = 3;
   localparam int CSR_IDX_W   = 2;
   localparam int QUEUE_DEPTH = 4;

   localparam logic [PIX_W-1:0]  PAD_VALUE  = 8'hFF;
   localparam logic [SIZE_W-1:0] WIDTH_RST  = 11'd1024;
   localparam logic [SIZE_W-1:0] HEIGHT_RST = 11'd1024;
   localparam logic [THR_W-1:0]  THR_RST    = 8'd55;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WIDTH  = 2'd0,
      CSR_HEIGHT = 2'd1,
      CSR_THRESH = 2'd2
   } csr_index_type;

   // one column of vertical minima plus what the back end must do with it
   typedef struct packed {
      logic [PIX_W-1:0] dark;
      logic             row_start;
      logic             emit_now;
      logic             last_col;
      logic             last_row;
      logic             sum_clear;
      logic [PH_W-1:0]  first_flush;
   } col_event_type;

   function automatic logic [PIX_W-1:0] min2(input logic [PIX_W-1:0] a,
                                             input logic [PIX_W-1:0] b);
      return (a < b) ? a : b;
   endfunction

endpackage

FILE: src/dark_channel_haze_detect.sv
// Top level of the dark-channel haze detector.
//
// Pixel words enter on req_* (kind, red, green, blue) in raster order, one per
// clock; an item is taken when req_valid is high and req_stall low. After the
// H image rows, RADIUS rows of W drain words (kind 1) flush the bottom rows.
// Dark values leave on rsp_* in raster order; a word moves when rsp_valid is
// high and rsp_stall low. rsp_last_of_frame marks the final value of a frame
// and rsp_haze_flag, valid with it, says the mean dark level reached the
// threshold plus one.
// Values flushed at a row end follow one per cycle while rsp_stall is low.
// Throughput: the front end takes one pixel per clock while req_stall is low.
// The back end holds the last column of each output row while it flushes
// RADIUS more values; the 4-word queue absorbs part of this, and once it is
// full req_stall is raised. The first RADIUS rows of a frame make no output.
// Configuration writes on csr_* are always taken (csr_ready high) and must
// only be issued while the block is idle; the threshold product is then
// recomputed through lim_a_ff and lim_ff.
// Reset clears counters, queue, window and sum; the line store needs no
// clearing. A stalled receiver holds the output register, backs up the queue
// and then stalls req_*.
module dark_channel_haze_detect #(
   parameter int MAX_WIDTH  = dchd_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = dchd_pkg::MAX_HEIGHT_DEF,
   parameter int RADIUS     = dchd_pkg::RADIUS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_kind,
   input  logic [dchd_pkg::PIX_W-1:0]     req_red,
   input  logic [dchd_pkg::PIX_W-1:0]     req_green,
   input  logic [dchd_pkg::PIX_W-1:0]     req_blue,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [dchd_pkg::PIX_W-1:0]     rsp_dark_value,
   output logic                           rsp_last_of_frame,
   output logic                           rsp_haze_flag,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [dchd_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [dchd_pkg::SIZE_W-1:0]    csr_wdata
);
   import dchd_pkg::*;

   localparam int WW  = $clog2(MAX_WIDTH + 1);
   localparam int HW  = $clog2(MAX_HEIGHT + 1);
   localparam int LAW = THR_W + 1 + WW;
   localparam int LW  = LAW + HW;
   localparam int EVW = $bits(col_event_type);

   logic [SIZE_W-1:0] width_ff, height_ff;
   logic [THR_W-1:0]  thr_ff;
   logic [WW-1:0]     width_eff;
   logic [HW-1:0]     height_eff;
   logic [LAW-1:0]    lim_a_ff;
   logic [LW-1:0]     lim_ff;

   logic              ev_full, ev_push, ev_pop, ev_valid;
   col_event_type     ev_in, ev_out;
   logic [EVW-1:0]    ev_out_bits;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RST;
         height_ff <= HEIGHT_RST;
         thr_ff    <= THR_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_WIDTH:  width_ff  <= csr_wdata;
            CSR_HEIGHT: height_ff <= csr_wdata;
            CSR_THRESH: thr_ff    <= csr_wdata[THR_W-1:0];
            default:    ;
         endcase
      end
   end

   // sizes clamped to 1..MAX
   always_comb begin
      if (width_ff == '0) begin
         width_eff = WW'(1);
      end else if (32'(width_ff) > 32'(MAX_WIDTH)) begin
         width_eff = WW'(MAX_WIDTH);
      end else begin
         width_eff = WW'(width_ff);
      end
      if (height_ff == '0) begin
         height_eff = HW'(1);
      end else if (32'(height_ff) > 32'(MAX_HEIGHT)) begin
         height_eff = HW'(MAX_HEIGHT);
      end else begin
         height_eff = HW'(height_ff);
      end
   end

   // haze limit (thr+1)*W*H, two registered multiplies
   always_ff @(posedge clock) begin
      lim_a_ff <= LAW'({1'b0, thr_ff} + 1'b1) * LAW'(width_eff);
      lim_ff   <= LW'(lim_a_ff) * LW'(height_eff);
   end

   dchd_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .RADIUS     (RADIUS),
      .WW         (WW),
      .HW         (HW)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_kind   (req_kind),
      .req_red    (req_red),
      .req_green  (req_green),
      .req_blue   (req_blue),
      .width_eff  (width_eff),
      .height_eff (height_eff),
      .ev_full    (ev_full),
      .ev_push    (ev_push),
      .ev_data    (ev_in)
   );

   dchd_fifo #(
      .DEPTH     (QUEUE_DEPTH),
      .WIDTH     (EVW)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (ev_push),
      .din       (ev_in),
      .full      (ev_full),
      .pop       (ev_pop),
      .not_empty (ev_valid),
      .dout      (ev_out_bits)
   );

   assign ev_out = col_event_type'(ev_out_bits);

   dchd_back #(
      .RADIUS            (RADIUS),
      .LW                (LW)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .ev_valid          (ev_valid),
      .ev_data           (ev_out),
      .ev_pop            (ev_pop),
      .limit             (lim_ff),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_dark_value    (rsp_dark_value),
      .rsp_last_of_frame (rsp_last_of_frame),
      .rsp_haze_flag     (rsp_haze_flag)
   );

endmodule

FILE: src/dchd_front.sv
// Front end: raster counters, line store and per-column vertical minimum.
module dchd_front #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024,
   parameter int RADIUS     = 3,
   parameter int WW         = 11,
   parameter int HW         = 11
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_kind,
   input  logic [dchd_pkg::PIX_W-1:0]  req_red,
   input  logic [dchd_pkg::PIX_W-1:0]  req_green,
   input  logic [dchd_pkg::PIX_W-1:0]  req_blue,
   input  logic [WW-1:0]               width_eff,
   input  logic [HW-1:0]               height_eff,
   input  logic                        ev_full,
   output logic                        ev_push,
   output dchd_pkg::col_event_type     ev_data
);
   import dchd_pkg::*;

   localparam int XW   = $clog2(MAX_WIDTH);
   localparam int YW   = $clog2(MAX_HEIGHT + RADIUS);
   localparam int NROW = 2 * RADIUS;
   localparam int MW   = PIX_W * NROW;

   logic [XW-1:0]   x_ff, x_in, xc;
   logic [YW-1:0]   y_ff, y_in, yc;
   logic            restart, last_x, in_img, accept;
   logic [PIX_W-1:0] pix_v;
   logic [NROW-1:0] rows_ok;
   logic            has_ev;
   col_event_type   ev_new;

   logic            s1_valid_ff, s1_has_ev_ff, s1_go;
   logic [XW-1:0]   s1_x_ff;
   logic [PIX_W-1:0] s1_v_ff;
   logic [NROW-1:0] s1_ok_ff;
   col_event_type   s1_ev_ff;

   logic [MW-1:0]   mem [MAX_WIDTH];
   logic [MW-1:0]   rd_ff, fwd_word_ff, col_word, new_word;
   logic            fwd_ff;
   logic [PIX_W-1:0] vmin;

   assign accept    = req_valid && !req_stall;
   assign s1_go     = s1_valid_ff && (!s1_has_ev_ff || !ev_full);
   assign req_stall = s1_valid_ff && !s1_go;
   assign ev_push   = s1_valid_ff && s1_has_ev_ff && !ev_full;

   always_comb begin
      restart = (32'(x_ff) >= 32'(width_eff)) ||
                (32'(y_ff) >= 32'(height_eff) + 32'(RADIUS));
      xc      = restart ? '0 : x_ff;
      yc      = restart ? '0 : y_ff;
      last_x  = (32'(xc) == 32'(width_eff) - 32'd1);
      in_img  = (32'(yc) < 32'(height_eff));
      pix_v   = (!in_img || req_kind) ? PAD_VALUE
                : min2(min2(req_red, req_green), req_blue);
      for (int k = 0; k < NROW; k++) begin
         rows_ok[k] = (32'(yc) > 32'(k));
      end
      x_in = last_x ? '0 : xc + 1'b1;
      y_in = yc;
      if (last_x) begin
         if (32'(yc) + 32'd1 >= 32'(height_eff) + 32'(RADIUS)) begin
            y_in = '0;
         end else begin
            y_in = yc + 1'b1;
         end
      end
      has_ev             = (32'(yc) >= 32'(RADIUS));
      ev_new.dark        = PAD_VALUE;
      ev_new.row_start   = (xc == '0);
      ev_new.emit_now    = (32'(xc) >= 32'(RADIUS));
      ev_new.last_col    = last_x;
      ev_new.last_row    = (32'(yc) == 32'(height_eff) - 32'd1 + 32'(RADIUS));
      ev_new.sum_clear   = (32'(yc) == 32'(RADIUS)) && (xc == '0);
      if (32'(xc) + 32'd1 >= 32'(RADIUS)) begin
         ev_new.first_flush = PH_W'(1);
      end else begin
         ev_new.first_flush = PH_W'(32'(RADIUS) - 32'(xc));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff        <= '0;
         y_ff        <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            x_ff        <= x_in;
            y_ff        <= y_in;
            s1_valid_ff <= 1'b1;
         end else if (s1_go) begin
            s1_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_x_ff      <= xc;
         s1_v_ff      <= pix_v;
         s1_ok_ff     <= rows_ok;
         s1_ev_ff     <= ev_new;
         s1_has_ev_ff <= has_ev;
         fwd_ff       <= s1_go && (s1_x_ff == xc);
         fwd_word_ff  <= new_word;
      end
   end

   // line store: one word per column holding the previous 2R rows, newest low
   always_ff @(posedge clock) begin
      if (s1_go) begin
         mem[s1_x_ff] <= new_word;
      end
      if (accept) begin
         rd_ff <= mem[xc];
      end
   end

   always_comb begin
      col_word = fwd_ff ? fwd_word_ff : rd_ff;
      new_word = {col_word[MW-PIX_W-1:0], s1_v_ff};
      vmin     = s1_v_ff;
      for (int k = 0; k < NROW; k++) begin
         if (s1_ok_ff[k]) begin
            vmin = min2(vmin, col_word[PIX_W*k +: PIX_W]);
         end
      end
      ev_data      = s1_ev_ff;
      ev_data.dark = vmin;
   end

endmodule

FILE: src/dchd_fifo.sv
// Short queue of column words between front and back end.
module dchd_fifo #(
   parameter int DEPTH = 4,
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] din,
   output logic             full,
   input  logic             pop,
   output logic             not_empty,
   output logic [WIDTH-1:0] dout
);
   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wr_ff, rd_ff;
   logic [CW-1:0]    cnt_ff;

   assign full      = (32'(cnt_ff) == 32'(DEPTH));
   assign not_empty = (cnt_ff != '0);
   assign dout      = slot_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= (32'(wr_ff) == 32'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
         end
         if (pop) begin
            rd_ff <= (32'(rd_ff) == 32'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
         end
         if (push && !pop) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else if (pop && !push) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= din;
      end
   end

endmodule

FILE: src/dchd_back.sv
// Back end: horizontal window minimum, row-end flush, frame sum and haze verdict.
module dchd_back #(
   parameter int RADIUS = 3,
   parameter int LW     = 31
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        ev_valid,
   input  dchd_pkg::col_event_type     ev_data,
   output logic                        ev_pop,
   input  logic [LW-1:0]               limit,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [dchd_pkg::PIX_W-1:0]  rsp_dark_value,
   output logic                        rsp_last_of_frame,
   output logic                        rsp_haze_flag
);
   import dchd_pkg::*;

   localparam int NWIN = 2 * RADIUS + 1;
   localparam int CMPW = (LW > SUM_W) ? LW : SUM_W;

   logic [PIX_W-1:0] win_ff [NWIN];
   logic [PIX_W-1:0] win_in [NWIN];
   logic [PH_W-1:0]  ph_ff, ph_in;
   logic [SUM_W-1:0] sum_ff, sum_base, sum_new;
   logic             go, emit, fin, flag;
   logic [PIX_W-1:0] dmin, shift_val;

   logic             out_valid_ff, out_last_ff, out_flag_ff;
   logic [PIX_W-1:0] out_dark_ff;

   assign go = ev_valid && (!out_valid_ff || !rsp_stall);

   always_comb begin
      shift_val = (ph_ff == '0) ? ev_data.dark : PAD_VALUE;
      for (int i = 0; i < NWIN; i++) begin
         if (i == 0) begin
            win_in[i] = shift_val;
         end else if (ph_ff == '0 && ev_data.row_start) begin
            win_in[i] = PAD_VALUE;
         end else begin
            win_in[i] = win_ff[i-1];
         end
      end
      dmin = PAD_VALUE;
      for (int i = 0; i < NWIN; i++) begin
         dmin = min2(dmin, win_in[i]);
      end
      if (ph_ff == '0) begin
         emit   = ev_data.emit_now;
         fin    = 1'b0;
         ev_pop = go && !ev_data.last_col;
         ph_in  = (go && ev_data.last_col) ? PH_W'(1) : ph_ff;
      end else begin
         emit   = (ph_ff >= ev_data.first_flush);
         fin    = ev_data.last_row && (32'(ph_ff) == 32'(RADIUS));
         ev_pop = go && (32'(ph_ff) == 32'(RADIUS));
         if (!go) begin
            ph_in = ph_ff;
         end else if (32'(ph_ff) == 32'(RADIUS)) begin
            ph_in = '0;
         end else begin
            ph_in = ph_ff + 1'b1;
         end
      end
      sum_base = (ph_ff == '0 && ev_data.sum_clear) ? '0 : sum_ff;
      sum_new  = sum_base + SUM_W'(dmin);
      flag     = (CMPW'(sum_new) >= CMPW'(limit));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ph_ff        <= '0;
         sum_ff       <= '0;
         out_valid_ff <= 1'b0;
         for (int i = 0; i < NWIN; i++) begin
            win_ff[i] <= PAD_VALUE;
         end
      end else begin
         ph_ff <= ph_in;
         if (go) begin
            for (int i = 0; i < NWIN; i++) begin
               win_ff[i] <= win_in[i];
            end
            if (emit) begin
               sum_ff <= fin ? '0 : sum_new;
            end else begin
               sum_ff <= sum_base;
            end
         end
         if (go && emit) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (go && emit) begin
         out_dark_ff <= dmin;
         out_last_ff <= fin;
         out_flag_ff <= fin && flag;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_dark_value    = out_dark_ff;
   assign rsp_last_of_frame = out_last_ff;
   assign rsp_haze_flag     = out_flag_ff;

   a_flag_on_last: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_flag_ff |-> out_last_ff)
      else $error("haze flag without end of frame");

   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      32'(ph_ff) <= 32'(RADIUS))
      else $error("flush phase out of range");

   a_sum_cleared: assert property (@(posedge clock) disable iff (reset)
      go && emit && fin |=> sum_ff == '0)
      else $error("frame sum not cleared after last word");

   a_flush_needs_word: assert property (@(posedge clock) disable iff (reset)
      ph_ff != '0 |-> ev_valid)
      else $error("flush running without a queued column");

endmodule
